@@ rtl/core/ptfa_pkg.sv @@
// ----------------------------------------------------------------------------
// ptfa_pkg
// Shared constants, types and the row decode function of the planar tile
// frame assembler.
// ----------------------------------------------------------------------------
package ptfa_pkg;

    // tiles across in the large layout, 2 to 4
    localparam int MAX_TILES_ACROSS = 4;

    localparam int TILE_BYTES  = 16;
    localparam int TILE_ROWS   = 8;
    localparam int PIX_W       = 64;
    localparam int ROW_NUM_W   = 5;
    localparam int TILES_SMALL = (MAX_TILES_ACROSS < 2) ? MAX_TILES_ACROSS : 2;
    localparam int TILES_LARGE = (MAX_TILES_ACROSS < 4) ? MAX_TILES_ACROSS : 4;

    localparam int TILE_W   = 2;                   // tile index within a band
    localparam int ACROSS_W = TILE_W + 1;          // holds the tile count
    localparam int ROW_W    = 3;                   // row within a tile
    localparam int OFFSET_W = TILE_W + 4;          // byte offset within a band
    localparam int LANES    = 2 * MAX_TILES_ACROSS;
    localparam int LANE_W   = TILE_W + 1;

    typedef logic [LANES-1:0][7:0] ptfa_raw_row_t;

    typedef enum logic [0:0] {
        ST_FILL,
        ST_EMIT
    } ptfa_state_t;

    typedef struct packed {
        logic store_byte;
        logic load_row;
    } ptfa_cmd_t;

    typedef struct packed {
        logic band_end;   // current offset is the last byte of the band
        logic row_last;   // next row to load is the last of the band
        logic out_free;   // output register can take a row this cycle
    } ptfa_sts_t;

    // Planar bytes of one raster row to 2-bit pixel indices, MSB leftmost.
    function automatic logic [PIX_W-1:0] decode_row(input ptfa_raw_row_t raw,
                                                    input logic [ACROSS_W-1:0] across);
        logic [PIX_W-1:0] px;
        px = '0;
        for (int t = 0; t < MAX_TILES_ACROSS; t++) begin
            if (ACROSS_W'(t) < across) begin
                for (int b = 0; b < 8; b++) begin
                    px[2*(t*8+b) +: 2] = {raw[2*t+1][7-b], raw[2*t][7-b]};
                end
            end
        end
        return px;
    endfunction

endpackage

@@ rtl/core/ptfa_ctrl.sv @@
// ----------------------------------------------------------------------------
// ptfa_ctrl
// Controller: takes bytes until a band is complete, then unloads its rows.
// ----------------------------------------------------------------------------
module ptfa_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  ptfa_pkg::ptfa_sts_t sts,
    output ptfa_pkg::ptfa_cmd_t cmd
);
    import ptfa_pkg::*;

    ptfa_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_FILL;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_FILL: begin
                if (s_tvalid && sts.band_end) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (sts.out_free && sts.row_last) begin
                    state_next = ST_FILL;
                end
            end
            default: state_next = ST_FILL;
        endcase
    end

    always_comb begin
        s_tready       = 1'b0;
        cmd.store_byte = 1'b0;
        cmd.load_row   = 1'b0;
        unique case (state_reg)
            ST_FILL: begin
                s_tready       = 1'b1;
                cmd.store_byte = s_tvalid;
            end
            ST_EMIT: begin
                cmd.load_row = sts.out_free;
            end
            default: ;
        endcase
    end

endmodule

@@ rtl/core/ptfa_datapath.sv @@
// ----------------------------------------------------------------------------
// ptfa_datapath
// Band buffer, byte and row counters, layout register and output register.
// ----------------------------------------------------------------------------
module ptfa_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic                              cfg_wr_data,
    input  logic [7:0]                        s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ptfa_pkg::PIX_W-1:0]        m_tdata,
    output logic [ptfa_pkg::ROW_NUM_W-1:0]    row_number,
    output logic                              m_tlast,
    input  ptfa_pkg::ptfa_cmd_t               cmd,
    output ptfa_pkg::ptfa_sts_t               sts
);
    import ptfa_pkg::*;

    // one word per tile row; byte lanes are lo/hi plane of each tile
    ptfa_raw_row_t band_mem [TILE_ROWS];

    logic                  layout_reg;
    logic [OFFSET_W-1:0]   offset_reg;
    logic [TILE_W-1:0]     band_reg;
    logic [TILE_W-1:0]     emit_band_reg;
    logic [ROW_W-1:0]      row_cnt_reg;
    logic                  out_valid_reg;
    ptfa_raw_row_t         raw_reg;
    logic [ROW_NUM_W-1:0]  row_num_reg;
    logic                  last_reg;

    logic [ACROSS_W-1:0]   across;
    logic [ACROSS_W+3:0]   band_bytes;
    logic                  band_end;
    logic                  band_last;
    logic [ROW_W-1:0]      wr_row;
    logic [LANE_W-1:0]     wr_lane;

    assign across     = layout_reg ? ACROSS_W'(TILES_LARGE) : ACROSS_W'(TILES_SMALL);
    assign band_bytes = {across, 4'b0000};
    assign band_end   = ({1'b0, offset_reg} == (band_bytes - (ACROSS_W+4)'(1)));
    assign band_last  = (band_reg == TILE_W'(across - ACROSS_W'(1)));
    assign wr_row     = offset_reg[3:1];
    assign wr_lane    = {offset_reg[OFFSET_W-1 -: TILE_W], offset_reg[0]};

    assign sts.band_end = band_end;
    assign sts.row_last = (row_cnt_reg == ROW_W'(TILE_ROWS - 1));
    assign sts.out_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (cmd.store_byte) begin
            band_mem[wr_row][wr_lane] <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            layout_reg <= 1'b0;
            offset_reg <= '0;
            band_reg   <= '0;
        end else if (cfg_wr_en) begin
            layout_reg <= cfg_wr_data;
            offset_reg <= '0;
            band_reg   <= '0;
        end else if (cmd.store_byte) begin
            if (band_end) begin
                offset_reg <= '0;
                band_reg   <= band_last ? '0 : band_reg + TILE_W'(1);
            end else begin
                offset_reg <= offset_reg + OFFSET_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.store_byte && band_end) begin
            emit_band_reg <= band_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.load_row) begin
                row_cnt_reg   <= row_cnt_reg + ROW_W'(1);
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_row) begin
            raw_reg     <= band_mem[row_cnt_reg];
            row_num_reg <= {emit_band_reg, row_cnt_reg};
            last_reg    <= (emit_band_reg == TILE_W'(across - ACROSS_W'(1)))
                           && (row_cnt_reg == ROW_W'(TILE_ROWS - 1));
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = decode_row(raw_reg, across);
    assign row_number = row_num_reg;
    assign m_tlast    = last_reg;

endmodule

@@ rtl/core/planar_tile_frame_assembler.sv @@
// ----------------------------------------------------------------------------
// planar_tile_frame_assembler
// Decodes 2-bit planar 8x8 tiles into raster rows of a square tile frame.
// ----------------------------------------------------------------------------
// Input: one planar tile byte per transaction on s_t*. Each tile is 16 bytes,
// low plane then high plane per row; tiles come in row-major order.
// cfg_wr_en/cfg_wr_data set the layout (0: 2x2 tiles, 1: 4x4 tiles) and
// restart the frame; write only while the block is idle.
// Output: one raster row per transaction on m_t*; tdata holds 2-bit pixels
// (pixel x in bits 2x+1:2x) and the row number above them, tlast marks the
// frame's last row.
// Timing: band bytes are taken one per cycle while filling. The last byte of a
// band hands the band to the row unloader, which loads its rows into the
// output register one per cycle while the output is free, from the single row
// read port of the band buffer; input is held off while the 8 rows of a band
// are unloaded. The last row may still wait in the output register while the
// next band streams in. A stalled receiver holds the unloader and, through it,
// the input. Reset clears the layout to 2x2 and restarts the frame; the band
// buffer needs no clearing since each band is written in full before read.
// ----------------------------------------------------------------------------
module planar_tile_frame_assembler (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,   // layout
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // [7:0] tile_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,       // [63:0] row_pixels, [68:64] row_number, [71:69] zero
    output logic        m_tlast        // last_row
);
    import ptfa_pkg::*;

    ptfa_cmd_t             cmd;
    ptfa_sts_t             sts;
    logic [PIX_W-1:0]      row_pixels;
    logic [ROW_NUM_W-1:0]  row_number;

    ptfa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ptfa_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (row_pixels),
        .row_number  (row_number),
        .m_tlast     (m_tlast),
        .cmd         (cmd),
        .sts         (sts)
    );

    assign m_tdata = {(72-PIX_W-ROW_NUM_W)'(0), row_number, row_pixels};

    // band completion stops input for the row unload
    a_band_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && sts.band_end) |=> !s_tready)
        else $error("input accepted right after band completion");

    // frame always ends on the bottom row of a tile
    a_last_on_tile_bottom: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (row_number[2:0] == 3'(TILE_ROWS - 1)))
        else $error("last row flag not on a tile bottom row");

    // row unload never overlaps byte storage
    a_no_load_while_store: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.load_row && cmd.store_byte))
        else $error("row load and byte store in the same cycle");

endmodule
